// ===== design/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by the cell, the top level and the port checker; depends on nothing.
package spq_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 8;
  localparam int FILL_W  = 5;
  localparam int STAT_W  = 2;

  localparam int IN_BITS  = 1 + VALUE_W + PRIO_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = VALUE_W + STAT_W + FILL_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // The operation that every cell of the row carries out.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP
  } cell_op_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic        [PRIO_W-1:0]  prio;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   ent;
  } cell_cmd_t;

  localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;

endpackage

// ===== design/sorted_priority_queue_top.sv =====
// Sorted priority queue: every accepted beat is answered with one result beat.
// A result beat appears the cycle after its input beat is taken.
// One beat per cycle while in_tready is high; the row of cells shifts in a single step.
// in_tready stays high while the output register is empty or being drained.
// Reset (rst_n low, synchronous) empties the queue and drops any result.
// Cell contents are not reset; only cells below the fill count are read.
module sorted_priority_queue_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // [0] func, [32:1] item_value, [40:33] item_priority, rest zero
  input  logic [spq_pkg::IN_W-1:0] in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // [31:0] out_value, [33:32] status, [38:34] fill_count, rest zero
  output logic [spq_pkg::OUT_W-1:0] out_tdata
);
  import spq_pkg::*;

  logic                      in_fire;
  func_t                     func;
  entry_t                    new_ent;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] res_value_r, res_value_nxt;
  status_t                   res_status_r, res_status_nxt;
  logic [CNT_W-1:0]          res_count_r;
  cell_cmd_t                 cmd;
  entry_t                    ents [DEPTH];
  logic [DEPTH-1:0]          gts;
  logic                      full, empty;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign func          = func_t'(in_tdata[0]);
  assign new_ent.value = in_tdata[VALUE_W:1];
  assign new_ent.prio  = in_tdata[VALUE_W+PRIO_W:VALUE_W+1];

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    cmd.op         = CELL_HOLD;
    cmd.ent        = new_ent;
    count_nxt      = count_r;
    res_value_nxt  = '0;
    res_status_nxt = ST_OK;
    out_valid_nxt  = out_valid_r && !out_tready;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      unique case (func)
        FUNC_ENQ: begin
          if (full) begin
            res_status_nxt = ST_FULL;
          end else begin
            cmd.op    = CELL_PUSH;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        FUNC_DEQ: begin
          if (empty) begin
            res_status_nxt = ST_EMPTY;
            res_value_nxt  = EMPTY_VALUE;
          end else begin
            cmd.op        = CELL_POP;
            res_value_nxt = ents[0].value;
            count_nxt     = count_r - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic   occ;
      logic   at_tail;
      entry_t left_ent;
      logic   left_gt;
      entry_t right_ent;

      assign occ     = (CNT_W'(i) < count_r);
      assign at_tail = (CNT_W'(i) == count_r);

      if (i == 0) begin : g_head
        assign left_ent = new_ent;
        assign left_gt  = 1'b0;
      end else begin : g_body
        assign left_ent = ents[i-1];
        assign left_gt  = gts[i-1];
      end

      // The last cell has nothing behind it; on removal it keeps its entry,
      // which then lies above the fill count and is never read.
      if (i == DEPTH - 1) begin : g_tail
        assign right_ent = ents[i];
      end else begin : g_mid
        assign right_ent = ents[i+1];
      end

      spq_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .occ       (occ),
        .at_tail   (at_tail),
        .left_ent  (left_ent),
        .left_gt   (left_gt),
        .right_ent (right_ent),
        .ent       (ents[i]),
        .gt        (gts[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_value_r  <= res_value_nxt;
      res_status_r <= res_status_nxt;
      res_count_r  <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({FILL_W'(res_count_r), res_status_r, res_value_r});

endmodule

// ===== design/spq_cell.sv =====
// One storage cell of the sorted row: holds an entry and shifts it toward
// its neighbors on insert or removal. Depends on spq_pkg.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic               occ,      // this cell lies below the fill count
  input  logic               at_tail,  // this cell is the first free one
  input  spq_pkg::entry_t    left_ent,
  input  logic               left_gt,
  input  spq_pkg::entry_t    right_ent,
  output spq_pkg::entry_t    ent,
  output logic               gt
);
  import spq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  assign ent = ent_r;
  // Sorted order makes this flag monotonic along the occupied cells.
  assign gt  = occ && (ent_r.prio > cmd.ent.prio);

  always_comb begin
    ent_nxt = ent_r;
    unique case (cmd.op)
      CELL_PUSH: begin
        if (left_gt) begin
          ent_nxt = left_ent;
        end else if (gt || at_tail) begin
          ent_nxt = cmd.ent;
        end
      end
      CELL_POP:  ent_nxt = right_ent;
      default:   ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

// ===== design/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sees only the top-level ports.
module spq_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [spq_pkg::OUT_W-1:0] out_tdata
);
  import spq_pkg::*;

  logic [STAT_W-1:0]  st;
  logic [FILL_W-1:0]  fill;
  logic [VALUE_W-1:0] val;

  assign val  = out_tdata[VALUE_W-1:0];
  assign st   = out_tdata[VALUE_W+STAT_W-1:VALUE_W];
  assign fill = out_tdata[VALUE_W+STAT_W+FILL_W-1:VALUE_W+STAT_W];

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Every accepted input beat yields a result beat in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted beat produced no result");

  // A refused enqueue reports a full queue.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_FULL |-> fill == FILL_W'(DEPTH) && val == '0)
    else $error("full status with wrong count or value");

  // A dequeue from an empty queue reports all ones and no entries.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_EMPTY |-> fill == '0 && val == EMPTY_VALUE)
    else $error("empty status with wrong count or value");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/sorted_priority_queue_top_test.sv =====
// Self-checking testbench for sorted_priority_queue_top: a scoreboard class keeps its
// own sorted copy of the queue and predicts every result beat from the accepted input beats.
// Depends on spq_pkg and the sorted_priority_queue_top RTL only.
module sorted_priority_queue_top_test;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_ITEMS_PER_PHASE = 400;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    status_t                   status;
    logic        [FILL_W-1:0]  fill;
  } reply_t;

  class queue_scoreboard;
    logic signed [VALUE_W-1:0] held_value [DEPTH];
    logic        [PRIO_W-1:0]  held_prio  [DEPTH];
    int                        held_count;
    reply_t                    awaited [$];
    int                        errors;

    function new();
      held_count = 0;
      errors = 0;
    endfunction

    // Applies one accepted operation to the shadow queue and queues its reply.
    function void note_request(func_t op, logic signed [VALUE_W-1:0] value,
                               logic [PRIO_W-1:0] prio);
      reply_t r;
      int     pos;
      r.value = '0;
      r.status = ST_OK;
      if (op == FUNC_ENQ) begin
        if (held_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // Equal numbers stay ahead of the newcomer, so ties leave in arrival order.
          pos = held_count;
          while (pos > 0 && held_prio[pos-1] > prio) begin
            held_value[pos] = held_value[pos-1];
            held_prio[pos] = held_prio[pos-1];
            pos--;
          end
          held_value[pos] = value;
          held_prio[pos] = prio;
          held_count++;
        end
      end else if (held_count == 0) begin
        r.value = EMPTY_VALUE;
        r.status = ST_EMPTY;
      end else begin
        r.value = held_value[0];
        for (int i = 0; i + 1 < held_count; i++) begin
          held_value[i] = held_value[i+1];
          held_prio[i] = held_prio[i+1];
        end
        held_count--;
      end
      r.fill = FILL_W'(held_count);
      awaited.push_back(r);
    endfunction

    function void check_response(logic [OUT_W-1:0] beat);
      reply_t                    exp;
      logic signed [VALUE_W-1:0] got_value;
      logic        [STAT_W-1:0]  got_status;
      logic        [FILL_W-1:0]  got_fill;
      got_value = beat[VALUE_W-1:0];
      got_status = beat[VALUE_W+STAT_W-1:VALUE_W];
      got_fill = beat[VALUE_W+STAT_W+FILL_W-1:VALUE_W+STAT_W];
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat value %0d status %0d fill %0d",
                 $time, got_value, got_status, got_fill);
        return;
      end
      exp = awaited.pop_front();
      if (got_value !== exp.value) begin
        errors++;
        $display("%0t: out_value expected %0d got %0d", $time, exp.value, got_value);
      end
      if (got_status !== exp.status) begin
        errors++;
        $display("%0t: status expected %0d got %0d", $time, exp.status, got_status);
      end
      if (got_fill !== exp.fill) begin
        errors++;
        $display("%0t: fill_count expected %0d got %0d", $time, exp.fill, got_fill);
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;

  queue_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_request = 1'b0;
  int  cycle_count = 0;

  sorted_priority_queue_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off when the sender asks for it.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_response(out_tdata);
    end
  end

  task automatic send_beat(func_t op, logic signed [VALUE_W-1:0] value,
                           logic [PRIO_W-1:0] prio);
    logic [IN_W-1:0] beat;
    beat = '0;
    beat[0] = op;
    beat[VALUE_W:1] = value;
    beat[VALUE_W+PRIO_W:VALUE_W+1] = prio;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= beat;
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, value, prio);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(15))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return -32'sd1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int   enq_pct;
    bit   narrow_prio;
    logic [PRIO_W-1:0] prio;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: dequeue from empty, extreme values and numbers, ties, fill up, refused enqueue.
    send_beat(FUNC_DEQ, $urandom, PRIO_W'($urandom));
    send_beat(FUNC_ENQ, 32'sh7FFF_FFFF, 8'd255);
    send_beat(FUNC_ENQ, 32'sh8000_0000, 8'd0);
    send_beat(FUNC_ENQ, -32'sd1, 8'd255);
    send_beat(FUNC_ENQ, 32'sd0, 8'd128);
    send_beat(FUNC_ENQ, 32'sh5555_5555, 8'h55);
    send_beat(FUNC_ENQ, 32'shAAAA_AAAA, 8'hAA);
    for (int i = 0; i < 10; i++) send_beat(FUNC_ENQ, 100 + i, 8'd7);
    send_beat(FUNC_ENQ, 32'sd12345, 8'd0);
    repeat (6) send_beat(FUNC_DEQ, $urandom, PRIO_W'($urandom));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      enq_pct = 50;
      narrow_prio = 1'b0;
      for (int k = 0; k < RANDOM_ITEMS_PER_PHASE; k++) begin
        // Swing between filling and draining so both the full and the empty ends are hit.
        if (k % 40 == 0) begin
          case ($urandom_range(2))
            0: enq_pct = 15;
            1: enq_pct = 50;
            default: enq_pct = 85;
          endcase
          narrow_prio = 1'($urandom_range(1));
        end
        if (phase == 0 && k == 100) hold_request = 1'b1;
        if (phase == 1 && k == 200) wait_drained();
        prio = narrow_prio ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom);
        send_beat(($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ, pick_value(), prio);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue_top.sv
design/spq_checker.sv
tb/sorted_priority_queue_top_test.sv
